@@ src/rset_pkg.sv @@
// ----------------------------------------------------------------------------
// Randomized set table package
// Sizes, operation and status codes, word types, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rset_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int DRAW_W   = 16;
    localparam int CNT_W    = $clog2(DRAW_W + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_RANDOM = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_MISS  = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [VAL_W-1:0] value;
        logic [DRAW_W-1:0]       random_draw;
    } req_t;

    typedef struct packed {
        logic                    success;
        logic [1:0]              status;
        logic signed [VAL_W-1:0] picked_value;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_MV_WR,
        S_DIV,
        S_PICK_RD,
        S_PICK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic       ready;
        logic       load_in;
        logic       match_en;
        logic       ins_write;
        logic       rd_last;
        logic       mv_write;
        logic       div_start;
        logic       div_step;
        logic       rd_pick;
        logic       res_load;
        logic       res_success;
        logic [1:0] res_status;
        logic       res_pick;
        logic       out_load;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] op;
        logic       hit;
        logic       full;
        logic       empty;
        logic       div_done;
        logic       out_free;
    } stat_t;

endpackage

@@ src/rset_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/rset_ctrl.sv @@
// ----------------------------------------------------------------------------
// Randomized set table controller
// Sequences the match, the update of the store, the serial modulo and the
// hand-over of each result word.
// ----------------------------------------------------------------------------
module rset_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  rset_pkg::stat_t stat,
    output rset_pkg::ctrl_t cmd
);

    rset_pkg::state_t state_reg;
    rset_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rset_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rset_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rset_pkg::S_MATCH;
                end
            end
            rset_pkg::S_MATCH:
            begin
                state_next = rset_pkg::S_DECIDE;
            end
            rset_pkg::S_DECIDE:
            begin
                case (stat.op)
                    rset_pkg::OP_REMOVE:
                    begin
                        state_next = stat.hit ? rset_pkg::S_MV_WR : rset_pkg::S_FINISH;
                    end
                    rset_pkg::OP_RANDOM:
                    begin
                        state_next = stat.empty ? rset_pkg::S_FINISH : rset_pkg::S_DIV;
                    end
                    default:
                    begin
                        state_next = rset_pkg::S_FINISH;
                    end
                endcase
            end
            rset_pkg::S_MV_WR:
            begin
                state_next = rset_pkg::S_FINISH;
            end
            rset_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = rset_pkg::S_PICK_RD;
                end
            end
            rset_pkg::S_PICK_RD:
            begin
                state_next = rset_pkg::S_PICK;
            end
            rset_pkg::S_PICK:
            begin
                state_next = rset_pkg::S_FINISH;
            end
            rset_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = rset_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rset_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            rset_pkg::S_IDLE:
            begin
                cmd.ready   = 1'b1;
                cmd.load_in = req_valid;
            end
            rset_pkg::S_MATCH:
            begin
                cmd.match_en = 1'b1;
            end
            rset_pkg::S_DECIDE:
            begin
                case (stat.op)
                    rset_pkg::OP_INSERT:
                    begin
                        cmd.res_load = 1'b1;
                        if (stat.hit)
                        begin
                            cmd.res_status = rset_pkg::STAT_MISS;
                        end
                        else if (stat.full)
                        begin
                            cmd.res_status = rset_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.ins_write   = 1'b1;
                            cmd.res_success = 1'b1;
                            cmd.res_status  = rset_pkg::STAT_OK;
                        end
                    end
                    rset_pkg::OP_REMOVE:
                    begin
                        if (stat.hit)
                        begin
                            cmd.rd_last = 1'b1;
                        end
                        else
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = rset_pkg::STAT_MISS;
                        end
                    end
                    rset_pkg::OP_RANDOM:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = rset_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = rset_pkg::STAT_OK;
                    end
                endcase
            end
            rset_pkg::S_MV_WR:
            begin
                cmd.mv_write    = 1'b1;
                cmd.res_load    = 1'b1;
                cmd.res_success = 1'b1;
                cmd.res_status  = rset_pkg::STAT_OK;
            end
            rset_pkg::S_DIV:
            begin
                cmd.div_step = !stat.div_done;
            end
            rset_pkg::S_PICK_RD:
            begin
                cmd.rd_pick = 1'b1;
            end
            rset_pkg::S_PICK:
            begin
                cmd.res_load    = 1'b1;
                cmd.res_success = 1'b1;
                cmd.res_status  = rset_pkg::STAT_OK;
                cmd.res_pick    = 1'b1;
            end
            rset_pkg::S_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ src/rset_dp.sv @@
// ----------------------------------------------------------------------------
// Randomized set table datapath
// Match cells, entry RAM, occupancy count, serial modulo unit, result and
// output registers.
// ----------------------------------------------------------------------------
module rset_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  rset_pkg::req_t  req,
    input  logic            rsp_stall,
    input  rset_pkg::ctrl_t cmd,
    output rset_pkg::stat_t stat,
    output logic            rsp_valid,
    output rset_pkg::rsp_t  rsp
);

    logic [1:0]                    op_reg;
    logic [rset_pkg::VAL_W-1:0]    value_reg;
    logic [rset_pkg::DRAW_W-1:0]   quo_reg;
    logic [rset_pkg::OCC_W-1:0]    rem_reg;
    logic [rset_pkg::CNT_W-1:0]    cnt_reg;
    logic [rset_pkg::OCC_W-1:0]    occ_reg;
    logic [rset_pkg::VAL_W-1:0]    cells_reg [rset_pkg::CAPACITY];
    logic [rset_pkg::CAPACITY-1:0] hit_vec_reg;
    logic                          res_success_reg;
    logic [1:0]                    res_status_reg;
    logic [rset_pkg::VAL_W-1:0]    res_picked_reg;
    logic                          rsp_valid_reg;
    rset_pkg::rsp_t                rsp_reg;

    logic [rset_pkg::IDX_W-1:0]    pos;
    logic [rset_pkg::IDX_W-1:0]    last;
    logic [rset_pkg::OCC_W:0]      rem_try;
    logic [rset_pkg::OCC_W-1:0]    rem_next;
    logic                          ram_we;
    logic [rset_pkg::IDX_W-1:0]    ram_waddr;
    logic [rset_pkg::VAL_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [rset_pkg::IDX_W-1:0]    ram_raddr;
    logic [rset_pkg::VAL_W-1:0]    ram_rdata;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < rset_pkg::CAPACITY; i++)
        begin
            if (hit_vec_reg[i])
            begin
                pos = pos | rset_pkg::IDX_W'(i);
            end
        end
    end

    assign last = rset_pkg::IDX_W'(occ_reg - rset_pkg::OCC_W'(1));

    assign rem_try  = {rem_reg, quo_reg[rset_pkg::DRAW_W-1]};
    assign rem_next = (rem_try >= {1'b0, occ_reg}) ?
                      rset_pkg::OCC_W'(rem_try - {1'b0, occ_reg}) :
                      rset_pkg::OCC_W'(rem_try);

    assign ram_we    = cmd.ins_write || cmd.mv_write;
    assign ram_waddr = cmd.ins_write ? occ_reg[rset_pkg::IDX_W-1:0] : pos;
    assign ram_wdata = cmd.ins_write ? value_reg : ram_rdata;
    assign ram_re    = cmd.rd_last || cmd.rd_pick;
    assign ram_raddr = cmd.rd_last ? last : rem_reg[rset_pkg::IDX_W-1:0];

    rset_ram #(
        .WIDTH (rset_pkg::VAL_W),
        .DEPTH (rset_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= req.operation;
            value_reg <= req.value;
            quo_reg   <= req.random_draw;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[rset_pkg::DRAW_W-2:0], 1'b0};
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.match_en)
        begin
            for (int i = 0; i < rset_pkg::CAPACITY; i++)
            begin
                hit_vec_reg[i] <= (rset_pkg::OCC_W'(i) < occ_reg) &&
                                  (cells_reg[i] == value_reg);
            end
        end
        for (int i = 0; i < rset_pkg::CAPACITY; i++)
        begin
            if (ram_we && (ram_waddr == rset_pkg::IDX_W'(i)))
            begin
                cells_reg[i] <= ram_wdata;
            end
        end
        if (cmd.res_load)
        begin
            res_success_reg <= cmd.res_success;
            res_status_reg  <= cmd.res_status;
            res_picked_reg  <= cmd.res_pick ? ram_rdata : '0;
        end
        if (cmd.out_load)
        begin
            rsp_reg.success      <= res_success_reg;
            rsp_reg.status       <= res_status_reg;
            rsp_reg.picked_value <= res_picked_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_write)
            begin
                occ_reg <= occ_reg + rset_pkg::OCC_W'(1);
            end
            else if (cmd.mv_write)
            begin
                occ_reg <= occ_reg - rset_pkg::OCC_W'(1);
            end
            if (cmd.div_start)
            begin
                cnt_reg <= rset_pkg::CNT_W'(rset_pkg::DRAW_W);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - rset_pkg::CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op       = op_reg;
    assign stat.hit      = |hit_vec_reg;
    assign stat.full     = (occ_reg == rset_pkg::OCC_W'(rset_pkg::CAPACITY));
    assign stat.empty    = (occ_reg == '0);
    assign stat.div_done = (cnt_reg == '0);
    assign stat.out_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/randomized_set_table.sv @@
// ----------------------------------------------------------------------------
// Randomized set table
// Set of distinct signed 32-bit values with insert, remove and get-random.
// ----------------------------------------------------------------------------
// A request word (operation, value, random draw) is taken on req when
// req_valid is high and req_stall is low; every request gives exactly one
// response word on rsp, held while rsp_stall is high.
// The block works on one request at a time and lowers req_stall only when
// it is free. Each request passes through match and decide; a remove that
// hits then writes the moved entry, get-random runs the serial modulo unit
// over the draw in 16 one-bit steps and reads the picked entry, and the
// result then waits to be handed to the output register.
// Matching compares all occupied cells at once in the match state.
// A finished response waits in the output register while the receiver
// stalls; the block then accepts the next request and holds its result
// until the output register is free.
// Insert of a new value into a full store reports full, get-random on an
// empty set reports empty and removal of an absent value reports not found.
// Reset clears the occupancy count and the handshake state; the entry
// store needs no clearing, since only entries below the count are read.
// ----------------------------------------------------------------------------
module randomized_set_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rset_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rset_pkg::rsp_t rsp
);

    rset_pkg::ctrl_t cmd;
    rset_pkg::stat_t stat;

    rset_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    rset_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    assign req_stall = !cmd.ready;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) cmd.ins_write |-> !stat.full)
        else $error("Insert written into a full store.");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.mv_write |-> !stat.empty)
        else $error("Remove applied to an empty store.");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.div_start |-> !stat.empty)
        else $error("Modulo started with a zero count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.success) |-> (rsp.status == rset_pkg::STAT_OK))
        else $error("Successful response carries a failure status.");
`endif

endmodule

@@ tb/rset_response_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Randomized set table response checker
// Watches the request and response channels of the set table and keeps its
// own copy of the set contents. Each accepted request word is turned into the
// response word it must cause and queued. Each accepted response word is
// compared field by field with the oldest queued one. Mismatches are counted
// and handed to the testbench top together with the number of words still
// owed.
// ----------------------------------------------------------------------------
module rset_response_check (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  rset_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  rset_pkg::rsp_t rsp,
    output int             mismatch_count,
    output int             outstanding
);

    logic signed [rset_pkg::VAL_W-1:0] set_cells [rset_pkg::CAPACITY];
    int                                set_count;
    rset_pkg::rsp_t                    owed_rsp [$];
    rset_pkg::rsp_t                    oldest_rsp;

    function automatic rset_pkg::rsp_t apply_set_op(rset_pkg::req_t r);
        rset_pkg::rsp_t o;
        int             pos;
        o   = '0;
        pos = -1;
        for (int i = 0; i < set_count; i++)
        begin
            if (pos < 0 && set_cells[i] == r.value)
            begin
                pos = i;
            end
        end
        case (r.operation)
            rset_pkg::OP_INSERT:
            begin
                if (pos >= 0)
                begin
                    o.status = rset_pkg::STAT_MISS;
                end
                else if (set_count >= rset_pkg::CAPACITY)
                begin
                    o.status = rset_pkg::STAT_FULL;
                end
                else
                begin
                    set_cells[set_count] = r.value;
                    set_count++;
                    o.success = 1'b1;
                end
            end
            rset_pkg::OP_REMOVE:
            begin
                if (pos < 0)
                begin
                    o.status = rset_pkg::STAT_MISS;
                end
                else
                begin
                    set_cells[pos] = set_cells[set_count - 1];
                    set_count--;
                    o.success = 1'b1;
                end
            end
            rset_pkg::OP_RANDOM:
            begin
                if (set_count == 0)
                begin
                    o.status = rset_pkg::STAT_EMPTY;
                end
                else
                begin
                    o.picked_value = set_cells[int'(r.random_draw) % set_count];
                    o.success      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [rset_pkg::VAL_W-1:0] got,
                                   logic [rset_pkg::VAL_W-1:0] want);
        $display("%0t ns: mismatch in %s: got %0h, expected %0h",
                 $time, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count = 0;
            owed_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_rsp.size() == 0)
                begin
                    report_mismatch("unexpected response word", rsp.picked_value, '0);
                end
                else
                begin
                    oldest_rsp = owed_rsp.pop_front();
                    if (rsp.success !== oldest_rsp.success)
                    begin
                        report_mismatch("success", rset_pkg::VAL_W'(rsp.success),
                                        rset_pkg::VAL_W'(oldest_rsp.success));
                    end
                    if (rsp.status !== oldest_rsp.status)
                    begin
                        report_mismatch("status", rset_pkg::VAL_W'(rsp.status),
                                        rset_pkg::VAL_W'(oldest_rsp.status));
                    end
                    if (rsp.picked_value !== oldest_rsp.picked_value)
                    begin
                        report_mismatch("picked_value", rsp.picked_value,
                                        oldest_rsp.picked_value);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                owed_rsp = {owed_rsp, apply_set_op(req)};
            end
            outstanding <= owed_rsp.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Randomized set table testbench
// Drives request words into the set table: a short directed run over the
// empty, boundary and ignored-code cases, then random blocks that fill,
// drain, mix or scramble the set from a fixed pool of values. Both sides
// idle and stall at random. A separate checker predicts and compares every
// response word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         POOL_SIZE     = 80;
    localparam int         RANDOM_ITEMS  = 1250;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 40;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE} mix_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    rset_pkg::req_t req_word  = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    rset_pkg::rsp_t rsp_word;

    int mismatch_count;
    int outstanding;
    int tx_max = 16;
    int rx_max = 16;
    int rsp_hold = 0;
    int next_hold;

    logic signed [rset_pkg::VAL_W-1:0] value_pool [POOL_SIZE];

    randomized_set_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_word)
    );

    rset_response_check response_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req_word),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp_word),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold  <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            next_hold = (rx_max == 0) ? 0 : $urandom_range(rx_max, 0);
            rsp_hold  <= next_hold;
            rsp_stall <= (next_hold != 0);
        end
        else if (rsp_valid && rsp_hold > 0)
        begin
            rsp_hold  <= rsp_hold - 1;
            rsp_stall <= (rsp_hold > 1);
        end
    end

    task automatic send_op(logic [1:0] op, logic signed [rset_pkg::VAL_W-1:0] v,
                           logic [rset_pkg::DRAW_W-1:0] d);
        rset_pkg::req_t w;
        int             gap;
        w.operation   = op;
        w.value       = v;
        w.random_draw = d;
        gap = (tx_max == 0) ? 0 : $urandom_range(tx_max, 0);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic drain_pending();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        mix_t                              mix;
        int                                roll;
        int                                block_len;
        int                                block_count;
        int                                random_sent;
        int                                cursor;
        logic [1:0]                        op;
        logic signed [rset_pkg::VAL_W-1:0] v;
        logic [rset_pkg::DRAW_W-1:0]       d;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            value_pool[i] = $urandom;
        end
        block_count = 0;
        random_sent = 0;
        cursor      = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(rset_pkg::OP_RANDOM, 32'h0000_0000, 16'hFFFF);
        send_op(rset_pkg::OP_REMOVE, 32'h0000_0000, 16'h0000);
        send_op(rset_pkg::OP_INSERT, 32'h8000_0000, 16'h0000);
        send_op(rset_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
        send_op(rset_pkg::OP_INSERT, 32'h0000_0000, 16'h0000);
        send_op(rset_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(rset_pkg::OP_INSERT, 32'h8000_0000, 16'h0000);
        send_op(rset_pkg::OP_RANDOM, 32'h0000_0000, 16'h0000);
        send_op(rset_pkg::OP_RANDOM, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(rset_pkg::OP_REMOVE, 32'h1234_5678, 16'h0000);
        send_op(rset_pkg::OP_REMOVE, 32'hFFFF_FFFF, 16'h0000);
        send_op(rset_pkg::OP_REMOVE, 32'h8000_0000, 16'hFFFF);
        send_op(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(OP_UNUSED, 32'h0000_0000, 16'h0000);
        send_op(rset_pkg::OP_RANDOM, 32'h0000_0000, 16'h0001);
        send_op(rset_pkg::OP_RANDOM, 32'hFFFF_FFFF, 16'hAAAA);
        send_op(rset_pkg::OP_REMOVE, 32'h7FFF_FFFF, 16'h5555);
        send_op(rset_pkg::OP_REMOVE, 32'h0000_0000, 16'h0000);
        send_op(rset_pkg::OP_RANDOM, 32'h0000_0000, 16'h5555);

        while (random_sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(7, 0);
            mix  = (roll < 3) ? MIX_FILL : (roll < 5) ? MIX_DRAIN :
                   (roll < 7) ? MIX_EVEN : MIX_NOISE;
            tx_max    = ($urandom_range(3, 0) == 0) ? 0 : 16;
            rx_max    = ($urandom_range(3, 0) == 0) ? 0 : 16;
            block_len = $urandom_range(120, 40);
            if (block_len > RANDOM_ITEMS - random_sent)
            begin
                block_len = RANDOM_ITEMS - random_sent;
            end
            repeat (block_len)
            begin
                roll = $urandom_range(99, 0);
                case (mix)
                    MIX_FILL:
                        op = (roll < 75) ? rset_pkg::OP_INSERT :
                             (roll < 85) ? rset_pkg::OP_REMOVE :
                             (roll < 97) ? rset_pkg::OP_RANDOM : OP_UNUSED;
                    MIX_DRAIN:
                        op = (roll < 15) ? rset_pkg::OP_INSERT :
                             (roll < 75) ? rset_pkg::OP_REMOVE :
                             (roll < 97) ? rset_pkg::OP_RANDOM : OP_UNUSED;
                    MIX_EVEN:
                        op = (roll < 40) ? rset_pkg::OP_INSERT :
                             (roll < 75) ? rset_pkg::OP_REMOVE :
                             (roll < 97) ? rset_pkg::OP_RANDOM : OP_UNUSED;
                    default:
                        op = 2'($urandom_range(3, 0));
                endcase
                if (mix == MIX_NOISE && $urandom_range(1, 0) == 1)
                begin
                    v = $urandom;
                end
                else if (op == rset_pkg::OP_INSERT && mix != MIX_NOISE)
                begin
                    v      = value_pool[cursor];
                    cursor = (cursor + 1) % POOL_SIZE;
                end
                else
                begin
                    v = value_pool[$urandom_range(POOL_SIZE - 1, 0)];
                end
                d = 16'($urandom_range(65535, 0));
                send_op(op, v, d);
                random_sent++;
            end
            if (block_count == 0 || $urandom_range(2, 0) == 0)
            begin
                drain_pending();
            end
            block_count++;
        end

        drain_pending();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
